// ===== hdl/css_pkg.sv =====
// Shared types, codes and helpers for the comment and whitespace stripper.
// Used by css_scan, css_queue and comment_space_stripper. No dependencies.
`default_nettype none

package css_pkg;

    // Deepest block comment nesting that is still counted
    localparam int MAX_NEST = 255;
    localparam int NEST_W   = $clog2(MAX_NEST + 1);

    // Scan modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_LINE   = 2'd1;
    localparam logic [1:0] MODE_BLOCK  = 2'd2;

    // Last unpaired mark seen inside a block comment
    localparam logic [1:0] MARK_NONE  = 2'd0;
    localparam logic [1:0] MARK_SLASH = 2'd1;
    localparam logic [1:0] MARK_STAR  = 2'd2;

    // End result error codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_UNCLOSED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // One output beat
    typedef struct packed {
        logic [7:0] out_char;
        logic       gap_before;
        logic       is_end;
        logic [1:0] error_code;
    } result_t;

    // Whitespace: tab through carriage return, and space
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/css_scan.sv =====
// Scanner state and the per-byte update; produces up to two results a beat.
// Depends on css_pkg.
`default_nettype none

module css_scan
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire logic [7:0]        in_char,
    input  wire logic              end_of_text,
    output logic [1:0]             res_count,
    output css_pkg::result_t       res0,
    output css_pkg::result_t       res1
);
    import css_pkg::*;

    logic [1:0]        mode_reg, mode_next;
    logic              slash_reg, slash_next;
    logic [1:0]        mark_reg, mark_next;
    logic [NEST_W-1:0] depth_reg, depth_next;
    logic              gap_reg, gap_next;
    logic              ovf_reg, ovf_next;

    result_t           slot0, slot1;
    logic [1:0]        cnt;
    logic              finished;
    logic [1:0]        err;

    // Per-byte update
    always_comb
    begin
        mode_next  = mode_reg;
        slash_next = slash_reg;
        mark_next  = mark_reg;
        depth_next = depth_reg;
        gap_next   = gap_reg;
        ovf_next   = ovf_reg;
        slot0      = '0;
        slot1      = '0;
        cnt        = 2'd0;
        finished   = 1'b0;
        err        = ERR_OK;

        if (end_of_text)
        begin
            if (ovf_reg)
                err = ERR_OVERFLOW;
            else if (mode_reg == MODE_BLOCK)
                err = ERR_UNCLOSED;
            if (slash_reg)
            begin
                slot0 = '{out_char: CH_SLASH, gap_before: gap_reg, is_end: 1'b0,
                          error_code: ERR_OK};
                slot1 = '{out_char: 8'd0, gap_before: 1'b0, is_end: 1'b1,
                          error_code: err};
                cnt   = 2'd2;
            end
            else
            begin
                slot0 = '{out_char: 8'd0, gap_before: gap_reg, is_end: 1'b1,
                          error_code: err};
                cnt   = 2'd1;
            end
            mode_next  = MODE_NORMAL;
            slash_next = 1'b0;
            mark_next  = MARK_NONE;
            depth_next = '0;
            gap_next   = 1'b0;
            ovf_next   = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_LINE:
                begin
                    if (in_char == CH_LF)
                        mode_next = MODE_NORMAL;
                end
                MODE_BLOCK:
                begin
                    if ((mark_reg == MARK_SLASH) && (in_char == CH_STAR))
                    begin
                        if (depth_reg >= NEST_W'(MAX_NEST))
                            ovf_next = 1'b1;
                        else
                            depth_next = depth_reg + 1'b1;
                        mark_next = MARK_NONE;
                    end
                    else if ((mark_reg == MARK_STAR) && (in_char == CH_SLASH))
                    begin
                        if (depth_reg <= NEST_W'(1))
                        begin
                            depth_next = '0;
                            mode_next  = MODE_NORMAL;
                        end
                        else
                            depth_next = depth_reg - 1'b1;
                        mark_next = MARK_NONE;
                    end
                    else if (in_char == CH_SLASH)
                        mark_next = MARK_SLASH;
                    else if (in_char == CH_STAR)
                        mark_next = MARK_STAR;
                    else
                        mark_next = MARK_NONE;
                end
                default:
                begin
                    // Held slash resolves first
                    if (slash_reg)
                    begin
                        slash_next = 1'b0;
                        if (in_char == CH_SLASH)
                        begin
                            mode_next = MODE_LINE;
                            finished  = 1'b1;
                        end
                        else if (in_char == CH_STAR)
                        begin
                            mode_next  = MODE_BLOCK;
                            depth_next = NEST_W'(1);
                            mark_next  = MARK_NONE;
                            finished   = 1'b1;
                        end
                        else
                        begin
                            slot0 = '{out_char: CH_SLASH, gap_before: gap_reg,
                                      is_end: 1'b0, error_code: ERR_OK};
                            cnt      = 2'd1;
                            gap_next = 1'b0;
                        end
                    end
                    // Fresh normal byte
                    if (!finished)
                    begin
                        if (is_space(in_char))
                            gap_next = 1'b1;
                        else if (in_char == CH_SLASH)
                            slash_next = 1'b1;
                        else
                        begin
                            if (cnt == 2'd0)
                            begin
                                slot0 = '{out_char: in_char, gap_before: gap_next,
                                          is_end: 1'b0, error_code: ERR_OK};
                                cnt   = 2'd1;
                            end
                            else
                            begin
                                slot1 = '{out_char: in_char, gap_before: gap_next,
                                          is_end: 1'b0, error_code: ERR_OK};
                                cnt   = 2'd2;
                            end
                            gap_next = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            slash_reg <= 1'b0;
            mark_reg  <= MARK_NONE;
            depth_reg <= '0;
            gap_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            slash_reg <= slash_next;
            mark_reg  <= mark_next;
            depth_reg <= depth_next;
            gap_reg   <= gap_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign res_count = take ? cnt : 2'd0;
    assign res0      = slot0;
    assign res1      = slot1;

endmodule

`default_nettype wire

// ===== hdl/css_queue.sv =====
// Four-entry result queue: takes up to two results a cycle, sends one a beat.
// Depends on css_pkg.
`default_nettype none

module css_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [1:0]        push_count,
    input  wire css_pkg::result_t  push0,
    input  wire css_pkg::result_t  push1,
    output logic                   room2,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output css_pkg::result_t       out_data
);
    import css_pkg::*;

    result_t    entry_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] wr_ptr_plus1;

    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + 2'd1;
    assign count_next   = count_reg + {1'b0, push_count} - {2'b00, pop};

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            entry_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push1;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_count;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

    assign room2     = (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);
    assign out_data  = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== hdl/comment_space_stripper.sv =====
// Top level of the comment and whitespace stripper.
// Depends on css_pkg, css_scan and css_queue.
//
// Usage:
//   Slave stream carries text: tdata = in_char, tlast = end of text (no byte).
//   Master stream carries results: tdata = kept byte (zero on the end beat),
//   tuser = gap_before and error_code, tlast = end result.
//   Each accepted beat is scanned in the cycle it is taken and gives zero,
//   one or two results (a released held slash plus the byte, or a flushed
//   slash plus the end result). Results are registered in a four-entry queue
//   and are offered on the master side in order, behind any already queued.
//   Throughput: one input beat per cycle while the master side takes one
//   result per cycle; a beat that gives two results needs two transfers
//   on the master side. s_axis_tready is high while the queue can hold two
//   more results, so a stalled receiver holds input off after two or three
//   beats that give results (beats that give none keep flowing); no result
//   is dropped.
//   Reset clears the scan state (normal text, no held slash, depth zero)
//   and empties the queue. After the end result the scan state returns to
//   its reset value, ready for the next text.
`default_nettype none

module comment_space_stripper
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  wire logic       s_axis_tlast,   // end_of_text
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_char
    output logic [2:0]      m_axis_tuser,   // [0] gap_before, [2:1] error_code
    output logic            m_axis_tlast    // is_end
);
    import css_pkg::*;

    logic       take;
    logic       room2;
    logic [1:0] res_count;
    result_t    res0, res1;
    result_t    head;

    assign s_axis_tready = room2;
    assign take          = s_axis_tvalid && room2;

    // Scanner
    css_scan u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .in_char     (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .res_count   (res_count),
        .res0        (res0),
        .res1        (res1)
    );

    // Result queue
    css_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (res_count),
        .push0      (res0),
        .push1      (res1),
        .room2      (room2),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (head)
    );

    assign m_axis_tdata = head.out_char;
    assign m_axis_tuser = {head.error_code, head.gap_before};
    assign m_axis_tlast = head.is_end;

endmodule

`default_nettype wire

// ===== hdl/css_checker.sv =====
// Port-level checks for comment_space_stripper, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module css_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [2:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // A stalled result beat stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // End beat carries no byte
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'd0)
        else $error("end beat with nonzero data");

    // Kept bytes never carry an error
    a_kept_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[2:1] == 2'd0)
        else $error("error code on kept byte");

    // Error code is one of the defined values
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[2:1] != 2'd3)
        else $error("undefined error code");

endmodule

bind comment_space_stripper css_checker u_css_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== verif/comment_space_stripper_test.sv =====
// Self-checking testbench for comment_space_stripper: directed table, then random text.
// Each accepted beat runs through a scan model; its results are compared as they come out.
// Depends on css_pkg and the comment_space_stripper RTL.
`timescale 1ns / 1ps

module comment_space_stripper_test;

    import css_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int RANDOM_ITEMS    = 1750;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 20;
    localparam int REPORT_LIMIT    = 10;
    localparam int N_DIRECTED      = 25;

    localparam result_t NO_BEAT = '0;

    // One row of the directed table; typed rows carry their expected beats
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        logic [1:0] n_typed;
        result_t    first;
        result_t    second;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // plain letter, then a space and the zero byte (gap flagged)
        '{8'h41, 1'b0, 1'b1, 2'd1, '{8'h41, 1'b0, 1'b0, ERR_OK}, NO_BEAT},
        '{CH_SPACE, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{8'h00, 1'b0, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b0, ERR_OK}, NO_BEAT},
        '{8'hFF, 1'b0, 1'b1, 2'd1, '{8'hFF, 1'b0, 1'b0, ERR_OK}, NO_BEAT},
        // held slash released by an ordinary byte: two beats
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{8'h78, 1'b0, 1'b1, 2'd2, '{CH_SLASH, 1'b0, 1'b0, ERR_OK},
            '{8'h78, 1'b0, 1'b0, ERR_OK}},
        // lone star, then a line comment with content
        '{CH_STAR, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{8'h71, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{CH_LF, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        // nested block comment, opened twice and closed twice
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{CH_STAR, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{CH_STAR, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{CH_STAR, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{CH_STAR, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        // tab, held slash flushed at end of text
        '{CH_TAB, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{8'h5A, 1'b1, 1'b1, 2'd2, '{CH_SLASH, 1'b1, 1'b0, ERR_OK},
            '{8'h00, 1'b0, 1'b1, ERR_OK}},
        // block comment left open at end of text
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{CH_STAR, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{8'hA5, 1'b1, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1, ERR_UNCLOSED}, NO_BEAT}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;     // [7:0] in_char
    logic       s_axis_tlast;     // end_of_text
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;     // [7:0] out_char
    logic [2:0] m_axis_tuser;     // [0] gap_before, [2:1] error_code
    logic       m_axis_tlast;     // is_end

    // Scan model state
    logic [1:0]        txt_mode;
    logic              slash_waiting;
    logic [1:0]        block_mark;
    logic [NEST_W-1:0] nest_level;
    logic              gap_seen;
    logic              overflow_flag;

    result_t    step_beats [$];
    result_t    expected_beats [$];
    logic [7:0] text_buf [$];

    int error_count     = 0;
    int cycle_count     = 0;
    int random_items    = 0;
    int burst_left      = 0;
    int hold_off_asks   = 0;
    int hold_off_served = 0;
    int hold_left       = 0;
    int stall_mode      = 0;
    int mode_left       = 0;

    comment_space_stripper DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Scan model
    // ---------------------------------------------------------------
    function automatic void clear_scan();
        txt_mode      = MODE_NORMAL;
        slash_waiting = 1'b0;
        block_mark    = MARK_NONE;
        nest_level    = '0;
        gap_seen      = 1'b0;
        overflow_flag = 1'b0;
    endfunction

    function automatic void keep_char(input logic [7:0] ch);
        step_beats.push_back(result_t'{ch, gap_seen, 1'b0, ERR_OK});
        gap_seen = 1'b0;
    endfunction

    // Beats that one input beat causes, left in step_beats
    function automatic void strip_predict(input logic [7:0] ch, input logic eot);
        logic [1:0] err;
        logic       opened;
        step_beats.delete();
        opened = 1'b0;
        if (eot)
        begin
            if (slash_waiting)
                keep_char(CH_SLASH);
            if (overflow_flag)
                err = ERR_OVERFLOW;
            else if (txt_mode == MODE_BLOCK)
                err = ERR_UNCLOSED;
            else
                err = ERR_OK;
            step_beats.push_back(result_t'{8'h00, gap_seen, 1'b1, err});
            clear_scan();
        end
        else if (txt_mode == MODE_LINE)
        begin
            if (ch == CH_LF)
                txt_mode = MODE_NORMAL;
        end
        else if (txt_mode == MODE_BLOCK)
        begin
            // head and tail pairs are disjoint: a matched pair clears the mark
            if (block_mark == MARK_SLASH && ch == CH_STAR)
            begin
                if (nest_level >= MAX_NEST)
                    overflow_flag = 1'b1;
                else
                    nest_level = nest_level + 1'b1;
                block_mark = MARK_NONE;
            end
            else if (block_mark == MARK_STAR && ch == CH_SLASH)
            begin
                if (nest_level != 0)
                    nest_level = nest_level - 1'b1;
                if (nest_level == 0)
                    txt_mode = MODE_NORMAL;
                block_mark = MARK_NONE;
            end
            else if (ch == CH_SLASH)
                block_mark = MARK_SLASH;
            else if (ch == CH_STAR)
                block_mark = MARK_STAR;
            else
                block_mark = MARK_NONE;
        end
        else
        begin
            // normal text: resolve a held slash first
            if (slash_waiting)
            begin
                slash_waiting = 1'b0;
                if (ch == CH_SLASH)
                begin
                    txt_mode = MODE_LINE;
                    opened   = 1'b1;
                end
                else if (ch == CH_STAR)
                begin
                    txt_mode   = MODE_BLOCK;
                    nest_level = NEST_W'(1);
                    block_mark = MARK_NONE;
                    opened     = 1'b1;
                end
                else
                    keep_char(CH_SLASH);
            end
            if (!opened)
            begin
                if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR))
                    gap_seen = 1'b1;
                else if (ch == CH_SLASH)
                    slash_waiting = 1'b1;
                else
                    keep_char(ch);
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Text generation
    // ---------------------------------------------------------------
    // Non-space, non-slash byte, mostly printable
    function automatic logic [7:0] pick_plain();
        logic [7:0] ch;
        do
            ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(8'h21, 8'h7E));
        while (ch == CH_SLASH || ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR));
        return ch;
    endfunction

    // Any byte that cannot form a pair inside a block comment
    function automatic logic [7:0] pick_quiet();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(0, 255));
        while (ch == CH_SLASH || ch == CH_STAR);
        return ch;
    endfunction

    function automatic logic [7:0] pick_space();
        int r;
        r = $urandom_range(9, 14);
        return (r == 14) ? CH_SPACE : 8'(r);
    endfunction

    // Well-formed text: words, whitespace, line and nested block comments, lone slashes, stray tail pairs
    task automatic build_clean_text();
        int depth;
        repeat ($urandom_range(3, 25))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    repeat ($urandom_range(1, 6)) text_buf.push_back(pick_plain());
                4:
                    repeat ($urandom_range(1, 3)) text_buf.push_back(pick_space());
                5:
                begin
                    text_buf.push_back(CH_SLASH);
                    text_buf.push_back(CH_SLASH);
                    repeat ($urandom_range(0, 8))
                        text_buf.push_back(($urandom_range(0, 1) == 0) ? pick_plain()
                                                                       : pick_quiet());
                    text_buf.push_back(CH_LF);
                end
                6, 7:
                begin
                    depth = $urandom_range(1, 3);
                    repeat (depth)
                    begin
                        text_buf.push_back(CH_SLASH);
                        text_buf.push_back(CH_STAR);
                        repeat ($urandom_range(0, 4)) text_buf.push_back(pick_quiet());
                    end
                    repeat (depth)
                    begin
                        text_buf.push_back(CH_STAR);
                        text_buf.push_back(CH_SLASH);
                        repeat ($urandom_range(0, 2)) text_buf.push_back(pick_quiet());
                    end
                end
                8:
                begin
                    // division-like lone slash
                    text_buf.push_back(CH_SLASH);
                    text_buf.push_back(pick_quiet());
                end
                default:
                begin
                    // tail pair in normal text is plain data
                    text_buf.push_back(CH_STAR);
                    text_buf.push_back(CH_SLASH);
                    text_buf.push_back(pick_quiet());
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------
    // Offer one beat and return at the edge it is taken
    task automatic drive_beat(input logic [7:0] ch, input logic eot);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eot;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic feed(input logic [7:0] ch, input logic eot);
        drive_beat(ch, eot);
        strip_predict(ch, eot);
        foreach (step_beats[k])
            expected_beats.push_back(step_beats[k]);
        random_items++;
    endtask

    // Idle the input until every expected beat has come out
    task automatic drain_pause();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_beats.size() != 0);
    endtask

    // ---------------------------------------------------------------
    // Receiver: stall pattern that changes mode, plus long hold-offs
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_off_served != hold_off_asks)
        begin
            hold_left       = HOLD_OFF_CYCLES;
            hold_off_served = hold_off_asks;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 120);
        end
        else
            mode_left--;

        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[2:1]};
            if (expected_beats.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: unexpected beat char=%02h gap=%b end=%b err=%0d",
                             $time, got.out_char, got.gap_before, got.is_end,
                             got.error_code);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display({"%0t: mismatch expected char=%02h gap=%b end=%b err=%0d,",
                                  " got char=%02h gap=%b end=%b err=%0d"},
                                 $time, want.out_char, want.gap_before, want.is_end,
                                 want.error_code, got.out_char, got.gap_before,
                                 got.is_end, got.error_code);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout with %0d beats outstanding", expected_beats.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin
        stim_row_t row;
        int        text_index;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        clear_scan();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = DIRECTED_ROWS[i];
            drive_beat(row.ch, row.eot);
            strip_predict(row.ch, row.eot);
            if (row.typed)
            begin
                if (row.n_typed >= 1)
                    expected_beats.push_back(row.first);
                if (row.n_typed == 2)
                    expected_beats.push_back(row.second);
            end
            else
            begin
                foreach (step_beats[k])
                    expected_beats.push_back(step_beats[k]);
            end
        end
        drain_pause();

        // Random texts, each closed by an end-of-text beat
        text_index = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            text_buf.delete();
            if (text_index == 5)
            begin
                // nest to the limit, one head pair past it, a few tails
                repeat (MAX_NEST + 1)
                begin
                    text_buf.push_back(CH_SLASH);
                    text_buf.push_back(CH_STAR);
                end
                repeat (3)
                begin
                    text_buf.push_back(CH_STAR);
                    text_buf.push_back(CH_SLASH);
                end
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                        build_clean_text();
                    6, 7:
                        repeat ($urandom_range(1, 40))
                        begin
                            case ($urandom_range(0, 7))
                                0, 1:    text_buf.push_back(CH_SLASH);
                                2, 3:    text_buf.push_back(CH_STAR);
                                4:       text_buf.push_back(pick_space());
                                5:       text_buf.push_back(CH_LF);
                                6:       text_buf.push_back(pick_plain());
                                default: text_buf.push_back(8'($urandom_range(0, 255)));
                            endcase
                        end
                    8:
                    begin
                        // clean text cut short
                        build_clean_text();
                        repeat ($urandom_range(0, text_buf.size() / 2)) void'(text_buf.pop_back());
                    end
                    default:
                        repeat ($urandom_range(0, 2))
                            text_buf.push_back(8'($urandom_range(0, 255)));
                endcase
            end

            // long receiver hold-off while the sender keeps offering
            if (text_index == 2 || text_index == 14)
                hold_off_asks++;

            while (text_buf.size() != 0)
                feed(text_buf.pop_front(), 1'b0);
            feed(8'($urandom_range(0, 255)), 1'b1);

            if (text_index % 7 == 3)
                drain_pause();
            text_index++;
        end

        // Wait for the tail, then let the output settle
        drain_pause();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_beats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
